// ===== hdl/sitda_pkg.sv =====
// Shared types, constants and the double-dabble step function for the
// signed integer to decimal ASCII unit. No dependencies.
package sitda_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumStages     = ValueWidth / StepsPerStage;
  localparam int unsigned IdxWidth      = $clog2(NumDigits);

  localparam logic [5:0] CharZero  = 6'd48;
  localparam logic [5:0] CharMinus = 6'd45;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] bin;
    bcd_t                  bcd;
  } conv_t;

  // A group of shift-and-add-3 steps: binary bits move MSB first into the BCD field.
  function automatic conv_t dabble(conv_t c);
    conv_t r;
    r = c;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (r.bcd[d] >= 4'd5) begin
          r.bcd[d] = r.bcd[d] + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/signed_int_to_decimal_ascii_unit.sv =====
// Signed 32-bit integer to decimal ASCII text, one character per transfer.
// Depends on sitda_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / value_i) takes one two's
//   complement integer per transfer. Output channel (out_valid_o /
//   out_ready_i / char_code_o / is_last_o) returns its decimal text, most
//   significant character first: an optional '-', then the digits without
//   leading zeros ('0' for zero). is_last_o marks the final character.
//   Path: the input transfer loads the sign/magnitude stage, then the value
//   passes 8 double-dabble stages of 4 shift steps each, then one load into
//   the character emitter, whose register drives the first character.
//   Throughput: a new value may enter every cycle while stage 0 has room;
//   the emitter sends one character per cycle while out_ready_i is high, and
//   a value's text is 1 to 11 characters long. If the next value waits in the
//   last stage, its first character follows the previous one's last without a gap.
//   Stalls: with out_ready_i low the current character holds and the
//   conversion pipeline fills, then in_ready_o drops. Nothing is lost.
//   Reset (rst_ni low, asynchronous) empties the pipeline and the emitter.
module signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [ValueWidth-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [5:0]                   char_code_o,
  output logic                         is_last_o
);

  // Conversion pipeline: stage 0 holds sign/magnitude, stages 1..N dabble.
  conv_t                stg_q     [NumStages+1];
  logic [NumStages:0]   stg_valid_q;
  logic [NumStages:0]   stg_take;
  logic [NumStages:0]   stg_space;

  // Character emitter
  logic                 em_valid_q, em_valid_d;
  logic                 em_sign_q,  em_sign_d;
  logic [IdxWidth-1:0]  em_idx_q,   em_idx_d;
  bcd_t                 em_bcd_q,   em_bcd_d;
  logic                 em_load_ok;
  logic                 em_load;
  logic                 out_fire;
  logic                 out_last;
  logic [IdxWidth-1:0]  top_idx;

  logic [ValueWidth-1:0] raw;
  logic [ValueWidth-1:0] mag;

  assign raw = value_i;
  assign mag = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;

  // Backpressure chain, last stage first
  always_comb begin
    for (int k = NumStages; k >= 0; k--) begin
      if (k == NumStages) begin
        stg_take[k] = stg_valid_q[k] && em_load_ok;
      end else begin
        stg_take[k] = stg_valid_q[k] && stg_space[k+1];
      end
      stg_space[k] = !stg_valid_q[k] || stg_take[k];
    end
  end

  assign in_ready_o = stg_space[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= '0;
    end else begin
      if (stg_space[0]) begin
        stg_valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= NumStages; k++) begin
        if (stg_space[k]) begin
          stg_valid_q[k] <= stg_take[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && stg_space[0]) begin
      stg_q[0].neg <= raw[ValueWidth-1];
      stg_q[0].bin <= mag;
      stg_q[0].bcd <= '0;
    end
  end

  for (genvar g = 1; g <= NumStages; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (stg_take[g-1]) begin
        stg_q[g] <= dabble(stg_q[g-1]);
      end
    end
  end

  // Highest nonzero digit; zero falls back to the units digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (stg_q[NumStages].bcd[d] != 4'd0) begin
        top_idx = IdxWidth'(d);
      end
    end
  end

  assign out_last   = !em_sign_q && (em_idx_q == '0);
  assign out_fire   = em_valid_q && out_ready_i;
  assign em_load_ok = !em_valid_q || (out_fire && out_last);
  assign em_load    = stg_valid_q[NumStages] && em_load_ok;

  always_comb begin
    em_valid_d = em_valid_q;
    em_sign_d  = em_sign_q;
    em_idx_d   = em_idx_q;
    em_bcd_d   = em_bcd_q;
    if (em_load) begin
      em_valid_d = 1'b1;
      em_sign_d  = stg_q[NumStages].neg;
      em_idx_d   = top_idx;
      em_bcd_d   = stg_q[NumStages].bcd;
    end else if (out_fire) begin
      if (em_sign_q) begin
        em_sign_d = 1'b0;
      end else if (em_idx_q == '0) begin
        em_valid_d = 1'b0;
      end else begin
        em_idx_d = em_idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_sign_q  <= 1'b0;
      em_idx_q   <= '0;
    end else begin
      em_valid_q <= em_valid_d;
      em_sign_q  <= em_sign_d;
      em_idx_q   <= em_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_bcd_q <= em_bcd_d;
  end

  assign out_valid_o = em_valid_q;
  assign is_last_o   = out_last;
  assign char_code_o = em_sign_q ? CharMinus : (CharZero + {2'b00, em_bcd_q[em_idx_q]});

endmodule

// ===== verif/signed_int_to_decimal_ascii_unit_tb.sv =====
// Testbench for signed_int_to_decimal_ascii_unit: directed and random integers in,
// decimal ASCII characters out, checked against a scoreboard predictor.
// Depends on sitda_pkg and the unit itself.
module signed_int_to_decimal_ascii_unit_tb;
  import sitda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned IdlePercent   = 27;
  localparam int unsigned RandomItems   = 76;
  localparam int unsigned DrainCycles   = 20;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } text_char_t;

  // Holds the characters still owed by the unit, oldest first.
  class decimal_text_scoreboard;
    text_char_t  owed_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Input transfer: format the value and queue its characters.
    function void note_value(logic [ValueWidth-1:0] v);
      logic                  neg;
      logic [ValueWidth-1:0] mag;
      logic [3:0]            digits [NumDigits];
      int                    nd;
      neg = v[ValueWidth-1];
      // unsigned negate: the most negative value maps onto itself, 2^31
      mag = neg ? (~v + 1'b1) : v;
      nd  = 0;
      if (mag == '0) begin
        owed_q.push_back('{code: CharZero, last: 1'b1});
      end else begin
        while (mag != '0) begin
          digits[nd] = 4'(mag % 32'd10);
          mag        = mag / 32'd10;
          nd++;
        end
        if (neg) begin
          owed_q.push_back('{code: CharMinus, last: 1'b0});
        end
        for (int i = nd - 1; i >= 0; i--) begin
          owed_q.push_back('{code: CharZero + 6'(digits[i]), last: (i == 0)});
        end
      end
    endfunction

    // Output transfer: compare with the oldest owed character.
    function void check_char(logic [5:0] code, logic last);
      text_char_t exp_c;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                 $time, code, last);
        errors++;
      end else begin
        exp_c = owed_q.pop_front();
        if (code !== exp_c.code) begin
          $display("%0t: char_code mismatch: expected %0d, actual %0d",
                   $time, exp_c.code, code);
          errors++;
        end
        if (last !== exp_c.last) begin
          $display("%0t: is_last mismatch: expected %0b, actual %0b",
                   $time, exp_c.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [ValueWidth-1:0] value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [5:0]                   char_code_o;
  logic                         is_last_o;

  decimal_text_scoreboard text_board = new();
  bit                     calm = 1'b0;   // no idling on either side while set
  int unsigned            stall_cycles = 0;

  logic [ValueWidth-1:0] directed_values [24] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, -32'sd100,
    32'd12345, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
    32'd1000000000, 32'd999999999, -32'sd1000000000, -32'sd999999999,
    32'd1234567890, -32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7,
    32'd1000000001
  };

  signed_int_to_decimal_ascii_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .is_last_o   (is_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly values of a random digit count, some fully random words.
  function automatic logic [ValueWidth-1:0] random_value();
    int unsigned pick;
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    logic        neg;
    pick = $urandom_range(0, 99);
    neg  = 1'($urandom_range(0, 1));
    if (pick < 30) begin
      return $urandom;
    end
    len = $urandom_range(1, NumDigits);
    lo  = 1;
    repeat (len - 1) lo = lo * 10;
    if (len == NumDigits) begin
      hi = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      hi = lo * 10 - 1;
    end
    if (len == 1) begin
      lo = 0;
    end
    mag = $urandom_range(lo, hi);
    return neg ? (~mag + 1) : mag;
  endfunction

  // Called right after a falling edge; returns right after a falling edge.
  task automatic send_value(input logic [ValueWidth-1:0] v);
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    text_board.note_value(v);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      text_board.check_char(char_code_o, is_last_o);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("** signed_int_to_decimal_ascii_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
    end

    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 30 && n < 60);
      send_value(random_value());
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (text_board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (text_board.errors == 0 && text_board.pending() == 0) begin
      $display("** signed_int_to_decimal_ascii_unit: PASSED **");
    end else begin
      $display("** signed_int_to_decimal_ascii_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sitda_pkg.sv
hdl/signed_int_to_decimal_ascii_unit.sv
verif/signed_int_to_decimal_ascii_unit_tb.sv
